// ===== hdl/jsu_pkg.sv =====
// Shared types, codes and helpers for the JSON string unescaper.
package jsu_pkg;

  localparam logic [7:0] CHAR_QUOTE = 8'h22;
  localparam logic [7:0] CHAR_BSLASH = 8'h5C;
  localparam logic [7:0] CHAR_SLASH = 8'h2F;
  localparam logic [7:0] CHAR_B = 8'h62;
  localparam logic [7:0] CHAR_F = 8'h66;
  localparam logic [7:0] CHAR_N = 8'h6E;
  localparam logic [7:0] CHAR_R = 8'h72;
  localparam logic [7:0] CHAR_T = 8'h74;
  localparam logic [7:0] CHAR_U = 8'h75;

  localparam logic [7:0] CTRL_BS = 8'h08;
  localparam logic [7:0] CTRL_FF = 8'h0C;
  localparam logic [7:0] CTRL_LF = 8'h0A;
  localparam logic [7:0] CTRL_CR = 8'h0D;
  localparam logic [7:0] CTRL_TAB = 8'h09;

  localparam logic [15:0] UTF8_MAX1 = 16'h007F;
  localparam logic [15:0] UTF8_MAX2 = 16'h07FF;
  localparam logic [7:0] UTF8_LEAD2 = 8'hC0;
  localparam logic [7:0] UTF8_LEAD3 = 8'hE0;
  localparam logic [7:0] UTF8_CONT = 8'h80;

  localparam logic [2:0] ERR_NONE = 3'd0;
  localparam logic [2:0] ERR_NO_OPEN = 3'd1;
  localparam logic [2:0] ERR_BAD_ESC = 3'd2;
  localparam logic [2:0] ERR_BAD_HEX = 3'd3;
  localparam logic [2:0] ERR_UNTERM_STR = 3'd4;
  localparam logic [2:0] ERR_UNTERM_ESC = 3'd5;
  localparam logic [2:0] ERR_INCOMPL_UNI = 3'd6;

  // Result buffer: must hold one worst-case group on top of what is queued.
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW = 2;
  localparam int MAX_GROUP = 3;

  // All results caused by one input beat.
  typedef struct packed {
    logic [1:0]      count;
    logic [2:0][7:0] bytes;
    logic            done;
    logic [2:0]      err;
  } jsu_group_t;

  // One queued result beat.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       done;
    logic [2:0] err;
  } jsu_entry_t;

  // Hex digit decode: valid flag plus nibble value.
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) r = {1'b1, 4'(c - 8'h30)};
    else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
    else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
    return r;
  endfunction

endpackage

// ===== hdl/jsu_decode.sv =====
// Scan state machine and per-byte decode into a group of result beats.
module jsu_decode (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               item_fire,
  input  logic [7:0]         item_byte,
  input  logic               item_eoi,
  output jsu_pkg::jsu_group_t grp
);

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_TEXT = 2'd1,
    MODE_ESC  = 2'd2,
    MODE_HEX  = 2'd3
  } mode_t;

  mode_t       mode_r, mode_nxt;
  logic [1:0]  hex_cnt_r, hex_cnt_nxt;
  logic [11:0] cp_high_r, cp_high_nxt;
  logic [4:0]  hv;
  logic [15:0] cp;

  assign hv = jsu_pkg::hex_value(item_byte);
  assign cp = {cp_high_r, hv[3:0]};

  always_comb begin
    mode_nxt    = mode_r;
    hex_cnt_nxt = hex_cnt_r;
    cp_high_nxt = cp_high_r;
    grp.count   = 2'd0;
    grp.bytes   = '0;
    grp.done    = 1'b0;
    grp.err     = jsu_pkg::ERR_NONE;
    case (mode_r)
      MODE_IDLE: begin
        if (item_eoi || item_byte != jsu_pkg::CHAR_QUOTE) begin
          grp.count = 2'd1;
          grp.err   = jsu_pkg::ERR_NO_OPEN;
        end else begin
          mode_nxt = MODE_TEXT;
        end
      end
      MODE_TEXT: begin
        if (item_eoi) begin
          grp.count = 2'd1;
          grp.err   = jsu_pkg::ERR_UNTERM_STR;
          mode_nxt  = MODE_IDLE;
        end else if (item_byte == jsu_pkg::CHAR_QUOTE) begin
          grp.count = 2'd1;
          grp.done  = 1'b1;
          mode_nxt  = MODE_IDLE;
        end else if (item_byte == jsu_pkg::CHAR_BSLASH) begin
          mode_nxt = MODE_ESC;
        end else begin
          grp.count    = 2'd1;
          grp.bytes[0] = item_byte;
        end
      end
      MODE_ESC: begin
        if (item_eoi) begin
          grp.count = 2'd1;
          grp.err   = jsu_pkg::ERR_UNTERM_ESC;
          mode_nxt  = MODE_IDLE;
        end else begin
          mode_nxt  = MODE_TEXT;
          grp.count = 2'd1;
          case (item_byte)
            jsu_pkg::CHAR_QUOTE,
            jsu_pkg::CHAR_BSLASH,
            jsu_pkg::CHAR_SLASH: grp.bytes[0] = item_byte;
            jsu_pkg::CHAR_B:     grp.bytes[0] = jsu_pkg::CTRL_BS;
            jsu_pkg::CHAR_F:     grp.bytes[0] = jsu_pkg::CTRL_FF;
            jsu_pkg::CHAR_N:     grp.bytes[0] = jsu_pkg::CTRL_LF;
            jsu_pkg::CHAR_R:     grp.bytes[0] = jsu_pkg::CTRL_CR;
            jsu_pkg::CHAR_T:     grp.bytes[0] = jsu_pkg::CTRL_TAB;
            jsu_pkg::CHAR_U: begin
              grp.count   = 2'd0;
              mode_nxt    = MODE_HEX;
              hex_cnt_nxt = 2'd0;
              cp_high_nxt = 12'd0;
            end
            default: begin
              grp.err  = jsu_pkg::ERR_BAD_ESC;
              mode_nxt = MODE_IDLE;
            end
          endcase
        end
      end
      default: begin
        if (item_eoi || !hv[4]) begin
          grp.count = 2'd1;
          grp.err   = item_eoi ? jsu_pkg::ERR_INCOMPL_UNI : jsu_pkg::ERR_BAD_HEX;
          mode_nxt  = MODE_IDLE;
        end else if (hex_cnt_r != 2'd3) begin
          hex_cnt_nxt = hex_cnt_r + 2'd1;
          cp_high_nxt = {cp_high_r[7:0], hv[3:0]};
        end else begin
          mode_nxt    = MODE_TEXT;
          hex_cnt_nxt = 2'd0;
          cp_high_nxt = 12'd0;
          if (cp <= jsu_pkg::UTF8_MAX1) begin
            grp.count    = 2'd1;
            grp.bytes[0] = cp[7:0];
          end else if (cp <= jsu_pkg::UTF8_MAX2) begin
            grp.count    = 2'd2;
            grp.bytes[0] = jsu_pkg::UTF8_LEAD2 | {3'd0, cp[10:6]};
            grp.bytes[1] = jsu_pkg::UTF8_CONT | {2'd0, cp[5:0]};
          end else begin
            grp.count    = 2'd3;
            grp.bytes[0] = jsu_pkg::UTF8_LEAD3 | {4'd0, cp[15:12]};
            grp.bytes[1] = jsu_pkg::UTF8_CONT | {2'd0, cp[11:6]};
            grp.bytes[2] = jsu_pkg::UTF8_CONT | {2'd0, cp[5:0]};
          end
        end
      end
    endcase
    // Any error or end marker drops back to waiting with cleared hex state.
    if (mode_nxt == MODE_IDLE) begin
      hex_cnt_nxt = 2'd0;
      cp_high_nxt = 12'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_IDLE;
      hex_cnt_r <= 2'd0;
      cp_high_r <= 12'd0;
    end else if (item_fire) begin
      mode_r    <= mode_nxt;
      hex_cnt_r <= hex_cnt_nxt;
      cp_high_r <= cp_high_nxt;
    end
  end

  a_hex_only_in_hex: assert property (@(posedge clk) disable iff (!rst_n)
    (hex_cnt_r != 2'd0) |-> (mode_r == MODE_HEX))
    else $error("hex digit count set outside unicode escape");

  a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == MODE_IDLE) |-> (cp_high_r == 12'd0))
    else $error("code point not cleared while waiting");

  a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
    (grp.err != jsu_pkg::ERR_NONE || grp.done) |-> (grp.count == 2'd1))
    else $error("error or end marker not a single result");

endmodule

// ===== hdl/jsu_result_fifo.sv =====
// Result queue: takes a group of up to three beats at once, drains one per cycle while not stalled.
module jsu_result_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  jsu_pkg::jsu_group_t grp,
  output logic                room,
  output logic                out_valid,
  input  logic                out_stall,
  output jsu_pkg::jsu_entry_t out_entry
);

  jsu_pkg::jsu_entry_t           mem_r [jsu_pkg::FIFO_DEPTH];
  logic [jsu_pkg::FIFO_AW-1:0]   wp_r, wp_nxt, rp_r, rp_nxt;
  logic [jsu_pkg::FIFO_AW:0]     cnt_r, cnt_nxt;
  logic [1:0]                    push_cnt;
  logic                          pop;

  assign room      = cnt_r <= (jsu_pkg::FIFO_AW + 1)'(jsu_pkg::FIFO_DEPTH - jsu_pkg::MAX_GROUP);
  assign out_valid = cnt_r != '0;
  assign pop       = out_valid && !out_stall;
  assign push_cnt  = push ? grp.count : 2'd0;
  assign out_entry = mem_r[rp_r];

  assign wp_nxt  = wp_r + jsu_pkg::FIFO_AW'(push_cnt);
  assign rp_nxt  = rp_r + jsu_pkg::FIFO_AW'(pop);
  assign cnt_nxt = cnt_r + (jsu_pkg::FIFO_AW + 1)'(push_cnt)
                   - (jsu_pkg::FIFO_AW + 1)'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Write each beat of the group into consecutive slots; flag the last one.
  always_ff @(posedge clk) begin
    for (int k = 0; k < jsu_pkg::MAX_GROUP; k++) begin
      if (2'(k) < push_cnt) begin
        mem_r[wp_r + jsu_pkg::FIFO_AW'(k)].data <= grp.bytes[k];
        mem_r[wp_r + jsu_pkg::FIFO_AW'(k)].last <= (2'(k) == push_cnt - 2'd1);
        mem_r[wp_r + jsu_pkg::FIFO_AW'(k)].done <= grp.done;
        mem_r[wp_r + jsu_pkg::FIFO_AW'(k)].err  <= grp.err;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (jsu_pkg::FIFO_AW + 1)'(jsu_pkg::FIFO_DEPTH))
    else $error("result queue overflow");

  a_push_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    (push_cnt != 2'd0) |-> room)
    else $error("group pushed without room");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (jsu_pkg::FIFO_AW'(wp_r - rp_r) == cnt_r[jsu_pkg::FIFO_AW-1:0]))
    else $error("queue pointers disagree with count");

endmodule

// ===== hdl/json_string_unescape.sv =====
// Top level of the JSON string unescaper: input stage, decoder and result queue.
//
// Feed a quoted JSON string one byte per input beat, starting at the opening
// quote; set in_end_of_input on a beat that marks the end of input (its byte
// is ignored). Each input beat causes zero to three result beats: decoded
// bytes (escapes resolved, \uXXXX expanded to 1-3 UTF-8 bytes), an end marker
// with out_string_done on the closing quote, or a single error beat with a
// nonzero out_error_code. out_last_of_run flags the final beat caused by one
// input beat. Both channels use valid/stall; a beat moves when valid is high
// and stall is low.
// With the queue empty, an accepted beat is registered in the input stage, then
// in the result queue, and out_valid rises. Throughput: one input beat per cycle
// while each causes at most one result and the receiver does not stall; a
// \u escape that expands to two or three UTF-8 bytes holds the input while
// the four-entry result queue drains them one beat per unstalled cycle.
// When the receiver stalls, queued results hold and the input stalls once
// the queue cannot take a worst-case group of three beats.
// Reset empties the stage and queue and returns the scanner to waiting for
// an opening quote.
module json_string_unescape (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_end_of_input,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_last_of_run,
  output logic       out_string_done,
  output logic [2:0] out_error_code
);

  logic                stage_valid_r, stage_valid_nxt;
  logic [7:0]          stage_byte_r;
  logic                stage_eoi_r;
  logic                in_fire;
  logic                stage_move;
  logic                room;
  jsu_pkg::jsu_group_t grp;
  jsu_pkg::jsu_entry_t entry;

  // Advance the staged beat only when the queue can absorb a full group.
  assign stage_move      = stage_valid_r && room;
  assign in_stall        = stage_valid_r && !room;
  assign in_fire         = in_valid && !in_stall;
  assign stage_valid_nxt = in_fire || (stage_valid_r && !stage_move);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_valid_r <= 1'b0;
    end else begin
      stage_valid_r <= stage_valid_nxt;
    end
  end

  // Payload of the input stage: load on every accepted beat, hold otherwise.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      stage_byte_r <= in_byte;
      stage_eoi_r  <= in_end_of_input;
    end
  end

  jsu_decode u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .item_fire (stage_move),
    .item_byte (stage_byte_r),
    .item_eoi  (stage_eoi_r),
    .grp       (grp)
  );

  jsu_result_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (stage_move),
    .grp       (grp),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_entry (entry)
  );

  assign out_byte        = entry.data;
  assign out_last_of_run = entry.last;
  assign out_string_done = entry.done;
  assign out_error_code  = entry.err;

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> stage_valid_r)
    else $error("input stalled with empty stage");

  a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (stage_valid_r && !stage_move) |=> (stage_valid_r && $stable(stage_byte_r)))
    else $error("stalled stage lost its beat");

  a_move_room: assert property (@(posedge clk) disable iff (!rst_n)
    (stage_valid_r && room) |-> stage_move)
    else $error("stage beat not advanced despite room");

endmodule

// ===== verif/jsu_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for the JSON string unescaper: predicts result beats and compares them.
module jsu_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        in_end_of_input,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [7:0]  out_byte,
  input  logic        out_last_of_run,
  input  logic        out_string_done,
  input  logic [2:0]  out_error_code,
  output int unsigned fail_count,
  output int unsigned pending
);

  typedef enum logic [1:0] {SCAN_WAIT, SCAN_TEXT, SCAN_ESC, SCAN_HEX} scan_t;

  scan_t               mode = SCAN_WAIT;
  logic [1:0]          digits = 2'd0;
  logic [11:0]         cp_high = 12'd0;
  jsu_pkg::jsu_entry_t expected_beats[$];
  int unsigned         fails = 0;

  // {is_hex, nibble}
  function automatic logic [4:0] nibble_of(input logic [7:0] c);
    if (c inside {[8'h30:8'h39]}) return {1'b1, c[3:0]};
    if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) return {1'b1, c[3:0] + 4'd9};
    return 5'd0;
  endfunction

  // Advance the scanner by one input beat and queue the result beats it causes.
  task automatic decode_beat(input logic [7:0] c, input logic eoi);
    jsu_pkg::jsu_entry_t grp[3];
    int                  n;
    int                  i;
    logic                done;
    logic [2:0]          err;
    logic [4:0]          hv;
    logic [15:0]         cp;
    n = 0;
    done = 1'b0;
    err = jsu_pkg::ERR_NONE;
    hv = nibble_of(c);
    for (i = 0; i < 3; i++) grp[i] = '0;
    case (mode)
      SCAN_WAIT: begin
        if (eoi || c != jsu_pkg::CHAR_QUOTE) err = jsu_pkg::ERR_NO_OPEN;
        else mode = SCAN_TEXT;
      end
      SCAN_TEXT: begin
        if (eoi) err = jsu_pkg::ERR_UNTERM_STR;
        else if (c == jsu_pkg::CHAR_QUOTE) begin
          done = 1'b1;
          mode = SCAN_WAIT;
          n = 1;
        end else if (c == jsu_pkg::CHAR_BSLASH) mode = SCAN_ESC;
        else begin
          grp[0].data = c;
          n = 1;
        end
      end
      SCAN_ESC: begin
        if (eoi) err = jsu_pkg::ERR_UNTERM_ESC;
        else begin
          mode = SCAN_TEXT;
          n = 1;
          case (c)
            jsu_pkg::CHAR_QUOTE, jsu_pkg::CHAR_BSLASH,
            jsu_pkg::CHAR_SLASH: grp[0].data = c;
            jsu_pkg::CHAR_B: grp[0].data = jsu_pkg::CTRL_BS;
            jsu_pkg::CHAR_F: grp[0].data = jsu_pkg::CTRL_FF;
            jsu_pkg::CHAR_N: grp[0].data = jsu_pkg::CTRL_LF;
            jsu_pkg::CHAR_R: grp[0].data = jsu_pkg::CTRL_CR;
            jsu_pkg::CHAR_T: grp[0].data = jsu_pkg::CTRL_TAB;
            jsu_pkg::CHAR_U: begin
              mode = SCAN_HEX;
              digits = 2'd0;
              cp_high = 12'd0;
              n = 0;
            end
            default: begin
              err = jsu_pkg::ERR_BAD_ESC;
              n = 0;
            end
          endcase
        end
      end
      default: begin
        if (eoi) err = jsu_pkg::ERR_INCOMPL_UNI;
        else if (!hv[4]) err = jsu_pkg::ERR_BAD_HEX;
        else if (digits != 2'd3) begin
          cp_high = {cp_high[7:0], hv[3:0]};
          digits++;
        end else begin
          cp = {cp_high, hv[3:0]};
          mode = SCAN_TEXT;
          digits = 2'd0;
          cp_high = 12'd0;
          if (cp <= jsu_pkg::UTF8_MAX1) begin
            grp[0].data = cp[7:0];
            n = 1;
          end else if (cp <= jsu_pkg::UTF8_MAX2) begin
            grp[0].data = jsu_pkg::UTF8_LEAD2 | {3'b0, cp[10:6]};
            grp[1].data = jsu_pkg::UTF8_CONT | {2'b0, cp[5:0]};
            n = 2;
          end else begin
            grp[0].data = jsu_pkg::UTF8_LEAD3 | {4'b0, cp[15:12]};
            grp[1].data = jsu_pkg::UTF8_CONT | {2'b0, cp[11:6]};
            grp[2].data = jsu_pkg::UTF8_CONT | {2'b0, cp[5:0]};
            n = 3;
          end
        end
      end
    endcase
    // any error drops back to waiting for an opening quote
    if (err != jsu_pkg::ERR_NONE) begin
      mode = SCAN_WAIT;
      digits = 2'd0;
      cp_high = 12'd0;
      grp[0].err = err;
      n = 1;
    end
    grp[0].done = done;
    for (i = 0; i < n; i++) begin
      grp[i].last = (i == n - 1);
      expected_beats = {expected_beats, grp[i]};
    end
  endtask

  always @(posedge clk) begin
    jsu_pkg::jsu_entry_t want;
    if (!rst_n) begin
      mode = SCAN_WAIT;
      digits = 2'd0;
      cp_high = 12'd0;
      expected_beats.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_beats.size() == 0) begin
          $error("unexpected result beat: out_byte %h last %b done %b err %0d",
                 out_byte, out_last_of_run, out_string_done, out_error_code);
          fails++;
        end else begin
          want = expected_beats.pop_front();
          if (out_byte !== want.data) begin
            $error("out_byte: expected %h, actual %h", want.data, out_byte);
            fails++;
          end
          if (out_last_of_run !== want.last) begin
            $error("out_last_of_run: expected %b, actual %b", want.last, out_last_of_run);
            fails++;
          end
          if (out_string_done !== want.done) begin
            $error("out_string_done: expected %b, actual %b", want.done, out_string_done);
            fails++;
          end
          if (out_error_code !== want.err) begin
            $error("out_error_code: expected %0d, actual %0d", want.err, out_error_code);
            fails++;
          end
        end
      end
      if (in_valid && !in_stall) decode_beat(in_byte, in_end_of_input);
    end
    pending <= expected_beats.size();
    fail_count <= fails;
  end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// Testbench top for the JSON string unescaper: stimulus, pacing and verdict.
module tb;

  localparam int unsigned RANDOM_BEATS = 250;
  localparam int unsigned HOLD_START   = 60;   // random beats before the long hold-off
  localparam int unsigned HOLD_CYCLES  = 100;
  localparam int unsigned DRAIN_CYCLES = 8;    // margin after the last expected beat
  localparam int unsigned CYCLE_LIMIT  = 200000;

  localparam logic [7:0] SIMPLE_ESC [8] = '{
    jsu_pkg::CHAR_QUOTE, jsu_pkg::CHAR_BSLASH, jsu_pkg::CHAR_SLASH, jsu_pkg::CHAR_B,
    jsu_pkg::CHAR_F, jsu_pkg::CHAR_N, jsu_pkg::CHAR_R, jsu_pkg::CHAR_T
  };
  // code points at the UTF-8 length boundaries, plus surrogate halves
  localparam logic [15:0] CP_EDGES [8] = '{
    16'h0000, 16'h007F, 16'h0080, 16'h07FF, 16'h0800, 16'hD800, 16'hDFFF, 16'hFFFF
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_byte = 8'h00;
  logic        in_end_of_input = 1'b0;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  out_byte;
  logic        out_last_of_run;
  logic        out_string_done;
  logic [2:0]  out_error_code;

  logic        rx_stall = 1'b0;   // per-beat random stall of the receiver
  logic        long_hold = 1'b0;  // one long hold-off to fill the block up
  logic        calm = 1'b0;       // stretches with no gaps on either side
  logic        hold_req = 1'b0;
  int unsigned sent = 0;
  int unsigned cycles = 0;
  int unsigned fail_count;
  int unsigned pending;

  assign out_stall = rx_stall | long_hold;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  json_string_unescape dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_byte         (in_byte),
    .in_end_of_input (in_end_of_input),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte        (out_byte),
    .out_last_of_run (out_last_of_run),
    .out_string_done (out_string_done),
    .out_error_code  (out_error_code)
  );

  jsu_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_byte         (in_byte),
    .in_end_of_input (in_end_of_input),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte        (out_byte),
    .out_last_of_run (out_last_of_run),
    .out_string_done (out_string_done),
    .out_error_code  (out_error_code),
    .fail_count      (fail_count),
    .pending         (pending)
  );

  // Bound the run: a hung handshake ends here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Offer one input beat after a random gap and hold it until accepted.
  // Drop valid only when a gap is drawn, so back-to-back beats keep it high.
  task automatic send_beat(input logic [7:0] b, input logic e);
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte <= b;
    in_end_of_input <= e;
    do @(posedge clk); while (in_stall);
    sent++;
  endtask

  // Send the top 'count' hex digits of cp, letters in random case.
  task automatic send_hex(input logic [15:0] cp, input int count);
    logic [3:0] nib;
    for (int k = 0; k < count; k++) begin
      nib = cp[(3 - k) * 4 +: 4];
      if (nib < 4'd10) send_beat(8'h30 + 8'(nib), 1'b0);
      else send_beat(($urandom_range(0, 1) ? 8'h61 : 8'h41) + 8'(nib) - 8'd10, 1'b0);
    end
  endtask

  // Spread code points over the 1-, 2- and 3-byte encodings.
  function automatic logic [15:0] draw_code_point();
    case ($urandom_range(0, 3))
      0:       return 16'($urandom_range(0, 'h7F));
      1:       return 16'($urandom_range('h80, 'h7FF));
      2:       return 16'($urandom_range('h800, 'hFFFF));
      default: return CP_EDGES[$urandom_range(0, 7)];
    endcase
  endfunction

  // One well-formed piece of string body: plain byte, short escape or \u escape.
  task automatic send_element();
    logic [7:0] b;
    case ($urandom_range(0, 3))
      0, 1: begin
        do b = 8'($urandom_range(0, 255));
        while (b == jsu_pkg::CHAR_QUOTE || b == jsu_pkg::CHAR_BSLASH);
        send_beat(b, 1'b0);
      end
      2: begin
        send_beat(jsu_pkg::CHAR_BSLASH, 1'b0);
        send_beat(SIMPLE_ESC[$urandom_range(0, 7)], 1'b0);
      end
      default: begin
        send_beat(jsu_pkg::CHAR_BSLASH, 1'b0);
        send_beat(jsu_pkg::CHAR_U, 1'b0);
        send_hex(draw_code_point(), 4);
      end
    endcase
  endtask

  // Receiver: raise a random stall ahead of each result beat (none while calm).
  initial begin : receiver
    int unsigned w;
    wait (rst_n === 1'b1);
    forever begin
      w = calm ? 0 : $urandom_range(0, 5);
      if (w != 0) begin
        rx_stall <= 1'b1;
        repeat (w) @(posedge clk);
      end
      rx_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  // Long hold-off, counted here, while the sender keeps offering beats.
  initial begin : long_holdoff
    wait (hold_req);
    @(posedge clk);
    long_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    long_hold <= 1'b0;
  end

  initial begin : stimulus
    int unsigned base;
    logic [7:0]  b;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Waiting for the opening quote: end of input and a stray byte both
    // flag a missing opening quote.
    send_beat(8'($urandom_range(0, 255)), 1'b1);
    send_beat(8'hFF, 1'b0);

    // Open, \uFfFf in mixed case (largest code point, three bytes),
    // a zero data byte, then the closing quote for the end marker.
    send_beat(jsu_pkg::CHAR_QUOTE, 1'b0);
    send_beat(jsu_pkg::CHAR_BSLASH, 1'b0);
    send_beat(jsu_pkg::CHAR_U, 1'b0);
    send_beat(8'h46, 1'b0);
    send_beat(8'h66, 1'b0);
    send_beat(8'h46, 1'b0);
    send_beat(8'h66, 1'b0);
    send_beat(8'h00, 1'b0);
    send_beat(jsu_pkg::CHAR_QUOTE, 1'b0);

    // Unknown escape letter.
    send_beat(jsu_pkg::CHAR_QUOTE, 1'b0);
    send_beat(jsu_pkg::CHAR_BSLASH, 1'b0);
    send_beat(8'h71, 1'b0);

    // A quote where a hex digit belongs is a bad hex digit.
    send_beat(jsu_pkg::CHAR_QUOTE, 1'b0);
    send_beat(jsu_pkg::CHAR_BSLASH, 1'b0);
    send_beat(jsu_pkg::CHAR_U, 1'b0);
    send_beat(8'h30, 1'b0);
    send_beat(jsu_pkg::CHAR_QUOTE, 1'b0);

    // End of input inside the string, after a backslash, and mid-\u.
    send_beat(jsu_pkg::CHAR_QUOTE, 1'b0);
    send_beat(8'($urandom_range(0, 255)), 1'b1);
    send_beat(jsu_pkg::CHAR_QUOTE, 1'b0);
    send_beat(jsu_pkg::CHAR_BSLASH, 1'b0);
    send_beat(8'($urandom_range(0, 255)), 1'b1);
    send_beat(jsu_pkg::CHAR_QUOTE, 1'b0);
    send_beat(jsu_pkg::CHAR_BSLASH, 1'b0);
    send_beat(jsu_pkg::CHAR_U, 1'b0);
    send_beat(8'h31, 1'b0);
    send_beat(8'($urandom_range(0, 255)), 1'b1);

    // Random part: mostly well-formed strings with random bodies, the rest
    // stray bytes, truncated strings, bad escapes and bad hex digits.
    base = sent;
    while (sent < base + RANDOM_BEATS) begin
      if (sent >= base + HOLD_START) hold_req = 1'b1;
      calm = ($urandom_range(0, 7) == 0);
      if ($urandom_range(0, 4) != 0) begin
        send_beat(jsu_pkg::CHAR_QUOTE, 1'b0);
        repeat ($urandom_range(0, 6)) send_element();
        send_beat(jsu_pkg::CHAR_QUOTE, 1'b0);
      end else begin
        case ($urandom_range(0, 3))
          0: send_beat(8'($urandom_range(0, 255)), ($urandom_range(0, 3) == 0));
          1: begin
            // cut the string short in text, after a backslash, or mid-\u
            send_beat(jsu_pkg::CHAR_QUOTE, 1'b0);
            repeat ($urandom_range(0, 3)) send_element();
            case ($urandom_range(0, 2))
              0: ;
              1: send_beat(jsu_pkg::CHAR_BSLASH, 1'b0);
              default: begin
                send_beat(jsu_pkg::CHAR_BSLASH, 1'b0);
                send_beat(jsu_pkg::CHAR_U, 1'b0);
                send_hex(draw_code_point(), $urandom_range(0, 3));
              end
            endcase
            send_beat(8'($urandom_range(0, 255)), 1'b1);
          end
          2: begin
            send_beat(jsu_pkg::CHAR_QUOTE, 1'b0);
            repeat ($urandom_range(0, 2)) send_element();
            send_beat(jsu_pkg::CHAR_BSLASH, 1'b0);
            do b = 8'($urandom_range(0, 255));
            while (b inside {jsu_pkg::CHAR_QUOTE, jsu_pkg::CHAR_BSLASH,
                             jsu_pkg::CHAR_SLASH, jsu_pkg::CHAR_B, jsu_pkg::CHAR_F,
                             jsu_pkg::CHAR_N, jsu_pkg::CHAR_R, jsu_pkg::CHAR_T,
                             jsu_pkg::CHAR_U});
            send_beat(b, 1'b0);
          end
          default: begin
            send_beat(jsu_pkg::CHAR_QUOTE, 1'b0);
            send_beat(jsu_pkg::CHAR_BSLASH, 1'b0);
            send_beat(jsu_pkg::CHAR_U, 1'b0);
            send_hex(draw_code_point(), $urandom_range(0, 3));
            if ($urandom_range(0, 3) == 0) b = jsu_pkg::CHAR_QUOTE;
            else begin
              do b = 8'($urandom_range(0, 255));
              while (b inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]});
            end
            send_beat(b, 1'b0);
          end
        endcase
      end
    end
    calm = 1'b0;

    // Drain: wait for every expected beat, then DRAIN_CYCLES more so a
    // stray extra beat still gets caught.
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
